@@ src/gtm_pkg.sv @@
// shared constants, types and codes for the gamepad thruster mixer
`timescale 1ns / 1ps

package gtm_pkg;

    // latched axis width
    localparam int VALUE_WIDTH = 16;

    // mix arithmetic width, wide enough for 2 * (256 - fwd - turn)
    localparam int CH_W = ((VALUE_WIDTH > 10) ? VALUE_WIDTH : 10) + 3;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CODE_W  = 10;
    localparam int RAW_W   = 16;
    localparam int CMD_W   = 11;
    localparam int NUM_CH  = 4;
    localparam int CH_IDX_W = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_AXIS   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUTTON = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    // event codes
    localparam logic [CODE_W-1:0] CODE_FWD   = 10'd1;
    localparam logic [CODE_W-1:0] CODE_LTRIG = 10'd2;
    localparam logic [CODE_W-1:0] CODE_TURN  = 10'd3;
    localparam logic [CODE_W-1:0] CODE_RTRIG = 10'd5;
    localparam logic [CODE_W-1:0] CODE_LBTN  = 10'h136;
    localparam logic [CODE_W-1:0] CODE_RBTN  = 10'h137;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LEVEL = 2'd3;

    // configuration reset values
    localparam logic [7:0]  DEADZONE_RST     = 8'd20;
    localparam logic [9:0]  OUTPUT_LIMIT_RST = 10'd200;
    localparam logic [15:0] SEND_PERIOD_RST  = 16'd100;
    localparam logic [7:0]  BUTTON_LEVEL_RST = 8'd250;

    // mixing constants
    localparam int MIX_CENTER = 128;
    localparam int WARN_LEVEL = 1000;
    localparam logic [NUM_CH-1:0]   ARM_RST  = 4'hF;
    localparam logic [15:0]         TICK_MAX = 16'hFFFF;
    localparam logic [CH_IDX_W-1:0] LAST_CH  = 2'd3;

    // one accepted input request
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [CODE_W-1:0]       code;
        logic signed [RAW_W-1:0] value;
    } item_t;

    // result of one firing, handed to the output buffer
    typedef struct packed {
        logic                         status;
        logic                         warn;
        logic [NUM_CH-1:0]            mask;
        logic [NUM_CH-1:0][CMD_W-1:0] cmd;
    } fire_t;

endpackage

@@ src/gamepad_thruster_mixer.sv @@
// top level of the gamepad thruster mixer
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_stall | func, code, value
//  out     | out_valid/out_stall | kind, channel, command, arm_status,
//          |                     | reconnect_warning, last
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// a request is mixed straight out of the input register, so its first result
// is registered in the result buffer and can leave while out_stall is low
// axis and button events go through at one per cycle; ticks do too while the
// result buffer is empty; a firing puts out one status result or four
// commands, one per cycle while out_stall is low; any further tick waits in
// the input register until the last of them leaves; reset clears control
// and valid state asynchronously; config registers return to their defaults
`timescale 1ns / 1ps

module gamepad_thruster_mixer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gtm_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [gtm_pkg::FUNC_W-1:0]           func,
    input  logic [gtm_pkg::CODE_W-1:0]           code,
    input  logic signed [gtm_pkg::RAW_W-1:0]     value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [gtm_pkg::CH_IDX_W-1:0]         channel,
    output logic signed [gtm_pkg::CMD_W-1:0]     command,
    output logic [gtm_pkg::NUM_CH-1:0]           arm_status,
    output logic                                 reconnect_warning,
    output logic                                 last
);

    gtm_pkg::item_t in_item;
    gtm_pkg::item_t item;
    gtm_pkg::fire_t fire_data;
    logic           item_valid;
    logic           take;
    logic           fire;
    logic           free;

    assign in_item.func  = func;
    assign in_item.code  = code;
    assign in_item.value = value;

    // a tick may fire, so it waits for room in the result buffer
    assign take = item_valid && ((item.func != gtm_pkg::FUNC_TICK) || free);

    gtm_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    gtm_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .fire      (fire),
        .fire_data (fire_data)
    );

    gtm_out_buf u_out_buf
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .fire_data         (fire_data),
        .free              (free),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .channel           (channel),
        .command           (command),
        .arm_status        (arm_status),
        .reconnect_warning (reconnect_warning),
        .last              (last)
    );

    // a status result stands alone and always carries a nonzero mask
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> last && (arm_status != '0))
        else $error("status result not last or mask empty");

    // a held request means the result buffer is still busy
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !take |-> out_valid)
        else $error("request held with empty result buffer");

    // a firing is never loaded over results still draining
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> free)
        else $error("firing loaded while buffer busy");

    // a command run continues without a gap until its last result
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && !kind
            && (channel == $past(channel) + 1'b1))
        else $error("command run broken");

endmodule

@@ src/gtm_in_stage.sv @@
// input register stage with stall back to the source
`timescale 1ns / 1ps

module gtm_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  gtm_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output gtm_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    gtm_pkg::item_t item_reg;
    logic           load;

    // hold while the registered request is not consumed
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    // occupancy
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/gtm_core.sv @@
// configuration, latched controls, tick timer, channel mixing and shaping
`timescale 1ns / 1ps

module gtm_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gtm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gtm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            take,
    input  gtm_pkg::item_t                  item,
    output logic                            fire,
    output gtm_pkg::fire_t                  fire_data
);

    localparam int VW    = gtm_pkg::VALUE_WIDTH;
    localparam int CW    = gtm_pkg::CH_W;
    localparam int CMDW  = gtm_pkg::CMD_W;
    localparam int NCH   = gtm_pkg::NUM_CH;
    localparam logic signed [CW-1:0] CENTER2  = CW'(2 * gtm_pkg::MIX_CENTER);
    localparam logic signed [CW-1:0] WARN_POS = CW'(gtm_pkg::WARN_LEVEL);
    localparam logic signed [CW-1:0] WARN_NEG = -CW'(gtm_pkg::WARN_LEVEL);

    // deadzone and clamp for one channel; top bit flags the deadzone
    function automatic logic [CMDW:0] shape_ch(input logic signed [CW-1:0] v,
                                               input logic [7:0] dz,
                                               input logic [9:0] lim);
        logic signed [CW-1:0]   mag;
        logic signed [CW-1:0]   lim_x;
        logic signed [CW-1:0]   lim_n;
        logic                   in_dz;
        logic signed [CMDW-1:0] cmd;
        mag   = (v < 0) ? -v : v;
        lim_x = $signed({{(CW-10){1'b0}}, lim});
        lim_n = -lim_x;
        in_dz = (mag == '0) || (mag < $signed({{(CW-8){1'b0}}, dz}));
        if (in_dz)
        begin
            cmd = '0;
        end
        else if (v > lim_x)
        begin
            cmd = lim_x[CMDW-1:0];
        end
        else if (v < lim_n)
        begin
            cmd = lim_n[CMDW-1:0];
        end
        else
        begin
            cmd = v[CMDW-1:0];
        end
        return {in_dz, cmd};
    endfunction

    // configuration registers
    logic [7:0]  deadzone_reg,     deadzone_next;
    logic [9:0]  output_limit_reg, output_limit_next;
    logic [15:0] send_period_reg,  send_period_next;
    logic [7:0]  button_level_reg, button_level_next;

    // control state
    logic signed [VW-1:0] fwd_reg,   fwd_next;
    logic signed [VW-1:0] turn_reg,  turn_next;
    logic signed [VW-1:0] lint_reg,  lint_next;
    logic signed [VW-1:0] rint_reg,  rint_next;
    logic [7:0]           lout_reg,  lout_next;
    logic [7:0]           rout_reg,  rout_next;
    logic [NCH-1:0]       mask_reg,  mask_next;
    logic [15:0]          ticks_reg, ticks_next;

    logic signed [VW-1:0] axis_val;
    logic [7:0]           btn_lvl;
    logic [15:0]          ticks_inc;
    logic                 fire_now;

    logic signed [CW-1:0] fwd_x, turn_x, lint_x, rint_x, lout_x, rout_x;
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] mix [NCH];
    logic [NCH-1:0]       dz_hit;
    logic [NCH-1:0][CMDW-1:0] cmds;
    logic [NCH-1:0]       mask_fired;

    // register writes
    always_comb
    begin
        deadzone_next     = deadzone_reg;
        output_limit_next = output_limit_reg;
        send_period_next  = send_period_reg;
        button_level_next = button_level_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gtm_pkg::REG_DEADZONE:     deadzone_next     = cfg_data[7:0];
                gtm_pkg::REG_OUTPUT_LIMIT: output_limit_next = cfg_data[9:0];
                gtm_pkg::REG_SEND_PERIOD:  send_period_next  = cfg_data[15:0];
                gtm_pkg::REG_BUTTON_LEVEL: button_level_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // channel mixing from the latched controls
    always_comb
    begin
        fwd_x  = CW'(fwd_reg);
        turn_x = CW'(turn_reg);
        lint_x = CW'(lint_reg);
        rint_x = CW'(rint_reg);
        lout_x = $signed({{(CW-8){1'b0}}, lout_reg});
        rout_x = $signed({{(CW-8){1'b0}}, rout_reg});
        diff   = turn_x - fwd_x;
        mix[0] = diff <<< 1;
        mix[1] = (CENTER2 - fwd_x - turn_x) <<< 1;
        mix[2] = (rint_x - rout_x) <<< 1;
        mix[3] = (lint_x - lout_x) <<< 1;
    end

    // deadzone and clamp on every channel
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            {dz_hit[i], cmds[i]} = shape_ch(mix[i], deadzone_reg, output_limit_reg);
        end
    end

    assign mask_fired = mask_reg & ~dz_hit;

    // saturating tick count and fire decision
    assign ticks_inc = (ticks_reg == gtm_pkg::TICK_MAX) ? ticks_reg : ticks_reg + 16'd1;
    assign fire_now  = take && (item.func == gtm_pkg::FUNC_TICK)
                       && (ticks_inc > send_period_reg);

    assign axis_val = VW'(item.value);
    assign btn_lvl  = (item.value != '0) ? button_level_reg : 8'd0;

    // state update per consumed request
    always_comb
    begin
        fwd_next   = fwd_reg;
        turn_next  = turn_reg;
        lint_next  = lint_reg;
        rint_next  = rint_reg;
        lout_next  = lout_reg;
        rout_next  = rout_reg;
        mask_next  = mask_reg;
        ticks_next = ticks_reg;
        if (take)
        begin
            unique case (item.func)
                gtm_pkg::FUNC_AXIS:
                begin
                    unique case (item.code)
                        gtm_pkg::CODE_FWD:   fwd_next  = axis_val;
                        gtm_pkg::CODE_TURN:  turn_next = axis_val;
                        gtm_pkg::CODE_LTRIG: lint_next = axis_val;
                        gtm_pkg::CODE_RTRIG: rint_next = axis_val;
                        default: ;
                    endcase
                end
                gtm_pkg::FUNC_BUTTON:
                begin
                    unique case (item.code)
                        gtm_pkg::CODE_LBTN: lout_next = btn_lvl;
                        gtm_pkg::CODE_RBTN: rout_next = btn_lvl;
                        default: ;
                    endcase
                end
                gtm_pkg::FUNC_TICK:
                begin
                    if (fire_now)
                    begin
                        ticks_next = '0;
                        mask_next  = mask_fired;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg     <= gtm_pkg::DEADZONE_RST;
            output_limit_reg <= gtm_pkg::OUTPUT_LIMIT_RST;
            send_period_reg  <= gtm_pkg::SEND_PERIOD_RST;
            button_level_reg <= gtm_pkg::BUTTON_LEVEL_RST;
            fwd_reg          <= '0;
            turn_reg         <= '0;
            lint_reg         <= '0;
            rint_reg         <= '0;
            lout_reg         <= '0;
            rout_reg         <= '0;
            mask_reg         <= gtm_pkg::ARM_RST;
            ticks_reg        <= '0;
        end
        else
        begin
            deadzone_reg     <= deadzone_next;
            output_limit_reg <= output_limit_next;
            send_period_reg  <= send_period_next;
            button_level_reg <= button_level_next;
            fwd_reg          <= fwd_next;
            turn_reg         <= turn_next;
            lint_reg         <= lint_next;
            rint_reg         <= rint_next;
            lout_reg         <= lout_next;
            rout_reg         <= rout_next;
            mask_reg         <= mask_next;
            ticks_reg        <= ticks_next;
        end
    end

    // firing result
    assign fire             = fire_now;
    assign fire_data.status = (mask_fired != '0);
    assign fire_data.warn   = (diff > WARN_POS) || (diff < WARN_NEG);
    assign fire_data.mask   = mask_fired;
    assign fire_data.cmd    = cmds;

endmodule

@@ src/gtm_out_buf.sv @@
// result register that drains one firing as one status or four commands
`timescale 1ns / 1ps

module gtm_out_buf
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  gtm_pkg::fire_t                       fire_data,
    output logic                                 free,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [gtm_pkg::CH_IDX_W-1:0]         channel,
    output logic signed [gtm_pkg::CMD_W-1:0]     command,
    output logic [gtm_pkg::NUM_CH-1:0]           arm_status,
    output logic                                 reconnect_warning,
    output logic                                 last
);

    logic                          valid_reg, valid_next;
    logic [gtm_pkg::CH_IDX_W-1:0]  idx_reg,   idx_next;
    gtm_pkg::fire_t                data_reg;
    logic                          is_last;
    logic                          sent;

    assign is_last = data_reg.status || (idx_reg == gtm_pkg::LAST_CH);
    assign sent    = valid_reg && !out_stall;

    // room for a new firing while empty or once the final result leaves
    assign free = !valid_reg || (sent && is_last);

    // drain sequencing
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (sent)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= fire_data;
        end
    end

    // result fields
    assign out_valid         = valid_reg;
    assign kind              = data_reg.status;
    assign channel           = data_reg.status ? '0 : idx_reg;
    assign command           = data_reg.status ? '0 : $signed(data_reg.cmd[idx_reg]);
    assign arm_status        = data_reg.status ? data_reg.mask : '0;
    assign reconnect_warning = data_reg.warn;
    assign last              = is_last;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the gamepad thruster mixer, with its own mixing predictor
`timescale 1ns / 1ps

module testbench;

    import gtm_pkg::*;

    // codes not named in the package
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CODE_W-1:0] CODE_IDLE   = 10'd0;
    localparam logic [CODE_W-1:0] CODE_TOP    = 10'h3FF;
    localparam logic              KIND_CMD    = 1'b0;
    localparam logic              KIND_STATUS = 1'b1;

    localparam int SCRIPT_LEN  = 24;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_REGS    = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 6;

    // one output request as the block should present it
    typedef struct packed {
        logic                    kind;
        logic [CH_IDX_W-1:0]     channel;
        logic signed [CMD_W-1:0] command;
        logic [NUM_CH-1:0]       arm_status;
        logic                    warn;
        logic                    last;
    } mix_result_t;

    // directed stimulus row; typed rows carry a hand-written status result
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [CODE_W-1:0]       code;
        logic signed [RAW_W-1:0] value;
        logic                    typed;
        logic [NUM_CH-1:0]       arm;
        logic                    warn;
    } script_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_DEADZONE;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [FUNC_W-1:0]       func = FUNC_TICK;
    logic [CODE_W-1:0]       code = CODE_IDLE;
    logic signed [RAW_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    kind;
    logic [CH_IDX_W-1:0]     channel;
    logic signed [CMD_W-1:0] command;
    logic [NUM_CH-1:0]       arm_status;
    logic                    reconnect_warning;
    logic                    last;

    // predictor copy of registers and state
    logic [7:0]              band_cfg   = DEADZONE_RST;
    logic [9:0]              limit_cfg  = OUTPUT_LIMIT_RST;
    logic [15:0]             period_cfg = SEND_PERIOD_RST;
    logic [7:0]              level_cfg  = BUTTON_LEVEL_RST;
    logic signed [RAW_W-1:0] fwd_pos = '0;
    logic signed [RAW_W-1:0] turn_pos = '0;
    logic signed [RAW_W-1:0] ltrig_pos = '0;
    logic signed [RAW_W-1:0] rtrig_pos = '0;
    logic [7:0]              lball = '0;
    logic [7:0]              rball = '0;
    logic [NUM_CH-1:0]       unarmed = ARM_RST;
    logic [15:0]             tick_count = '0;

    mix_result_t fired [NUM_CH];
    mix_result_t due_results [$];
    mix_result_t want;

    int  mismatches = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  status_firings = 0;
    int  command_firings = 0;
    int  settings_used = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    // walk from reset through arming, then the command path and deadzone edge
    script_row_t script [SCRIPT_LEN] = '{
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        // all axes at rest: only channel 1 sits outside the deadzone
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b1, 4'b0010, 1'b0},
        '{FUNC_AXIS,   CODE_FWD,   16'sh7FFF, 1'b0, 4'b0000, 1'b0},
        '{FUNC_AXIS,   CODE_TURN,  16'sh8000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_AXIS,   CODE_LTRIG, 16'sh8000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_AXIS,   CODE_RTRIG, 16'sh7FFF, 1'b0, 4'b0000, 1'b0},
        '{FUNC_BUTTON, CODE_LBTN,  16'sh0001, 1'b0, 4'b0000, 1'b0},
        '{FUNC_BUTTON, CODE_RBTN,  16'sh8000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_TOP,   16'shFFFF, 1'b0, 4'b0000, 1'b0},
        // full-scale axes: huge turn minus forward raises the warning
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b1, 4'b0010, 1'b1},
        '{FUNC_AXIS,   CODE_FWD,   16'sh0080, 1'b0, 4'b0000, 1'b0},
        '{FUNC_AXIS,   CODE_TURN,  16'sh0080, 1'b0, 4'b0000, 1'b0},
        // ignored: unknown item kind, unknown axis code, unknown button code
        '{FUNC_UNUSED, CODE_FWD,   16'sh03E8, 1'b0, 4'b0000, 1'b0},
        '{FUNC_AXIS,   CODE_TOP,   16'sh7FFF, 1'b0, 4'b0000, 1'b0},
        '{FUNC_BUTTON, CODE_IDLE,  16'sh0001, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_BUTTON, CODE_LBTN,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        // left ballast exactly at the deadzone, then just below it
        '{FUNC_AXIS,   CODE_LTRIG, 16'sh000A, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_AXIS,   CODE_LTRIG, 16'sh0009, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0},
        '{FUNC_TICK,   CODE_IDLE,  16'sh0000, 1'b0, 4'b0000, 1'b0}
    };

    gamepad_thruster_mixer dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .code              (code),
        .value             (value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .channel           (channel),
        .command           (command),
        .arm_status        (arm_status),
        .reconnect_warning (reconnect_warning),
        .last              (last)
    );

    always #2 clk = ~clk;

    // deadzone forces zero and disarms the channel, then symmetric clamp
    function automatic longint band_clamp(input longint raw, input int idx);
        longint mag;
        longint drive;
        mag = (raw < 0) ? -raw : raw;
        drive = raw;
        if (mag == 0 || mag < longint'(band_cfg))
        begin
            drive = 0;
            unarmed[idx] = 1'b0;
        end
        if (drive > longint'(limit_cfg))
            drive = longint'(limit_cfg);
        if (drive < -longint'(limit_cfg))
            drive = -longint'(limit_cfg);
        return drive;
    endfunction

    // latch events, count ticks and mix the channels on a firing
    task automatic advance_mixer(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] c,
                                 input logic signed [RAW_W-1:0] v, output int n);
        longint fwd_l;
        longint turn_l;
        longint diff;
        longint mix [NUM_CH];
        logic   warn;
        int     i;
        n = 0;
        case (f)
            FUNC_AXIS:
            begin
                if (c == CODE_FWD)
                    fwd_pos = v;
                else if (c == CODE_TURN)
                    turn_pos = v;
                else if (c == CODE_LTRIG)
                    ltrig_pos = v;
                else if (c == CODE_RTRIG)
                    rtrig_pos = v;
            end
            FUNC_BUTTON:
            begin
                if (c == CODE_LBTN)
                    lball = (v != 0) ? level_cfg : 8'd0;
                else if (c == CODE_RBTN)
                    rball = (v != 0) ? level_cfg : 8'd0;
            end
            FUNC_TICK:
            begin
                if (tick_count != TICK_MAX)
                    tick_count = tick_count + 16'd1;
                if (tick_count > period_cfg)
                begin
                    tick_count = '0;
                    fwd_l = fwd_pos;
                    turn_l = turn_pos;
                    diff = turn_l - fwd_l;
                    warn = (diff > WARN_LEVEL) || (diff < -WARN_LEVEL);
                    mix[0] = 2 * diff;
                    mix[1] = 2 * (2 * MIX_CENTER - fwd_l - turn_l);
                    mix[2] = 2 * (longint'(rtrig_pos) - longint'(rball));
                    mix[3] = 2 * (longint'(ltrig_pos) - longint'(lball));
                    for (i = 0; i < NUM_CH; i++)
                        mix[i] = band_clamp(mix[i], i);
                    if (unarmed != '0)
                    begin
                        fired[0] = '{KIND_STATUS, '0, '0, unarmed, warn, 1'b1};
                        n = 1;
                        status_firings++;
                    end
                    else
                    begin
                        for (i = 0; i < NUM_CH; i++)
                            fired[i] = '{KIND_CMD, CH_IDX_W'(i), CMD_W'(mix[i]), '0, warn,
                                         CH_IDX_W'(i) == LAST_CH};
                        n = NUM_CH;
                        command_firings++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // offer one request, wait for acceptance, queue what it should produce
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] c,
                                input logic signed [RAW_W-1:0] v, input int gap,
                                input logic use_typed, input mix_result_t typed_res);
        int n;
        int i;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        code <= c;
        value <= v;
        do @(posedge clk); while (in_stall !== 1'b0);
        requests_sent++;
        advance_mixer(f, c, v, n);
        if (use_typed)
            due_results.push_back(typed_res);
        else
            for (i = 0; i < n; i++)
                due_results.push_back(fired[i]);
    endtask

    // drop valid and let every queued result and in-flight request drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write all four registers on consecutive cycles
    task automatic write_regs(input logic [7:0] dz, input logic [9:0] lim,
                              input logic [15:0] per, input logic [7:0] lvl);
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            cfg_we <= 1'b1;
            case (i)
                0:
                begin
                    cfg_index <= REG_DEADZONE;
                    cfg_data <= CFG_W'(dz);
                end
                1:
                begin
                    cfg_index <= REG_OUTPUT_LIMIT;
                    cfg_data <= CFG_W'(lim);
                end
                2:
                begin
                    cfg_index <= REG_SEND_PERIOD;
                    cfg_data <= per;
                end
                default:
                begin
                    cfg_index <= REG_BUTTON_LEVEL;
                    cfg_data <= CFG_W'(lvl);
                end
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        band_cfg = dz;
        limit_cfg = lim;
        period_cfg = per;
        level_cfg = lvl;
        settings_used++;
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // axis positions: full range, near center, near the ballast level, extremes, near zero
    function automatic logic signed [RAW_W-1:0] pick_axis_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return RAW_W'($urandom);
            4, 5, 6:    return RAW_W'(MIX_CENTER - 700 + $urandom_range(0, 1400));
            7:          return RAW_W'(int'(level_cfg) - 12 + $urandom_range(0, 24));
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default:    return RAW_W'($urandom_range(0, 40) - 20);
        endcase
    endfunction

    // mostly ticks and known events, the rest noise
    task automatic pick_request(output logic [FUNC_W-1:0] f, output logic [CODE_W-1:0] c,
                                output logic signed [RAW_W-1:0] v);
        int pick;
        pick = $urandom_range(0, 99);
        c = CODE_W'($urandom_range(0, 1023));
        v = RAW_W'($urandom);
        if (pick < 40)
            f = FUNC_TICK;
        else if (pick < 75)
        begin
            f = FUNC_AXIS;
            case ($urandom_range(0, 3))
                0:       c = CODE_FWD;
                1:       c = CODE_TURN;
                2:       c = CODE_LTRIG;
                default: c = CODE_RTRIG;
            endcase
            v = pick_axis_value();
        end
        else if (pick < 87)
        begin
            f = FUNC_BUTTON;
            c = ($urandom_range(0, 1) == 0) ? CODE_LBTN : CODE_RBTN;
            if ($urandom_range(0, 1) == 0)
                v = '0;
            else
                v = RAW_W'($urandom_range(1, 65535));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       f = FUNC_UNUSED;
                1:       f = FUNC_AXIS;
                default: f = FUNC_BUTTON;
            endcase
        end
    endtask

    // output check against the oldest queued result
    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d channel %0d command %0d", kind, channel,
                       command);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                check_field("kind", want.kind, kind);
                check_field("channel", want.channel, channel);
                check_field("command", $signed(want.command), command);
                check_field("arm_status", want.arm_status, arm_status);
                check_field("reconnect_warning", want.warn, reconnect_warning);
                check_field("last", want.last, last);
            end
        end
    end

    // receiver: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int stall_left;
        int quiet_left;
        int pick;
        stall_left = 0;
        quiet_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (quiet_left > 0)
            begin
                out_stall <= 1'b0;
                quiet_left--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    quiet_left = $urandom_range(20, 60);
                else if (pick < 13)
                    stall_left = $urandom_range(8, 25);
                else if (pick < 40)
                    stall_left = $urandom_range(1, 3);
                out_stall <= 1'b0;
            end
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("** gamepad_thruster_mixer: FAILED **");
        $finish;
    end

    // reset, directed script, then random phases under changing settings
    initial
    begin
        int r;
        int p;
        int k;
        int n_items;
        bit steady;
        logic [FUNC_W-1:0] f;
        logic [CODE_W-1:0] c;
        logic signed [RAW_W-1:0] v;
        logic [7:0] dz;
        logic [9:0] lim;
        logic [15:0] per;
        logic [7:0] lvl;
        mix_result_t typed_res;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs(DEADZONE_RST, OUTPUT_LIMIT_RST, 16'd1, BUTTON_LEVEL_RST);
        for (r = 0; r < SCRIPT_LEN; r++)
        begin
            typed_res = '{KIND_STATUS, '0, '0, script[r].arm, script[r].warn, 1'b1};
            send_request(script[r].func, script[r].code, script[r].value, pick_gap(1'b0),
                         script[r].typed, typed_res);
        end
        for (p = 1; p <= NUM_PHASES; p++)
        begin
            dz = 8'($urandom_range(0, 255));
            lim = 10'($urandom_range(0, 1023));
            per = 16'($urandom_range(1, 4));
            lvl = 8'($urandom_range(0, 255));
            case (p)
                1:
                begin
                    dz = 8'd0;
                    lim = 10'd1023;
                    per = 16'd1;
                    lvl = 8'd255;
                end
                2:
                begin
                    dz = 8'd255;
                    lim = 10'd0;
                    per = 16'd2;
                    lvl = 8'd0;
                end
                3: per = 16'hFFFF;
                default: ;
            endcase
            n_items = (p == 3) ? 12 : 30;
            steady = (p == 1 || p == 4);
            wait_idle();
            write_regs(dz, lim, per, lvl);
            // long output hold-off while requests keep coming
            if (p == 4)
                hold_req = 1'b1;
            for (k = 0; k < n_items; k++)
            begin
                pick_request(f, c, v);
                send_request(f, c, v, pick_gap(steady), 1'b0, typed_res);
            end
        end
        wait_idle();
        $display("run covered %0d requests under %0d register settings, one long hold-off",
                 requests_sent, settings_used);
        $display("checked %0d results from %0d status and %0d command firings",
                 results_checked, status_firings, command_firings);
        if (mismatches == 0 && due_results.size() == 0)
            $display("** gamepad_thruster_mixer: PASSED **");
        else
            $display("** gamepad_thruster_mixer: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
src/gtm_pkg.sv
src/gtm_in_stage.sv
src/gtm_core.sv
src/gtm_out_buf.sv
src/gamepad_thruster_mixer.sv
sim/testbench.sv
